[hw/rtl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, operation and status codes, beat types and saturation
// helpers for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int NORM_W = DATA_W - 1;
  localparam int RAD_W  = 2 * DATA_W;
  localparam int ROOT_W = DATA_W;
  localparam int DEN_W  = DATA_W + 1;
  localparam int NUM_W  = DATA_W + FRAC_W;
  localparam int SAT_W  = 67;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_HAM   = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;
  localparam logic [2:0] OP_MAG   = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic [DEN_W-1:0] NORM_MAX = {2'b00, {NORM_W{1'b1}}};

  typedef struct packed {
    logic [2:0]  op;
    word_t [3:0] a;
    word_t [3:0] b;
    word_t       s;
  } req_t;

  typedef struct packed {
    logic [2:0]  op;
    word_t [3:0] a;
    word_t       s;
    word_t [3:0] rf;
    logic        f;
    logic        carry;
  } mid_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        neg;
    word_t [3:0]       rf;
    logic              f;
    logic              divz;
    logic [NORM_W-1:0] nv;
    logic              fmag;
  } tail_t;

  typedef struct packed {
    word_t [3:0]       r;
    logic [NORM_W-1:0] nv;
    logic [1:0]        status;
  } rsp_t;

  function automatic word_t sat_val(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return MAX_WORD;
    end else if (v < SAT_LO) begin
      return MIN_WORD;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic sat_ovf(input logic signed [SAT_W-1:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

endpackage

[hw/rtl/qau_req_if.sv]
// ----------------------------------------------------------------------------
// qau_req_if
// Request channel: operation code, quaternions A and B and a scalar.
// ----------------------------------------------------------------------------
interface qau_req_if import qau_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [DATA_W-1:0] a_w;
  logic signed [DATA_W-1:0] a_i;
  logic signed [DATA_W-1:0] a_j;
  logic signed [DATA_W-1:0] a_k;
  logic signed [DATA_W-1:0] b_w;
  logic signed [DATA_W-1:0] b_i;
  logic signed [DATA_W-1:0] b_j;
  logic signed [DATA_W-1:0] b_k;
  logic signed [DATA_W-1:0] scalar;

  modport source (output valid, req_type, a_w, a_i, a_j, a_k, b_w, b_i, b_j, b_k,
                  scalar, input ready);
  modport sink (input valid, req_type, a_w, a_i, a_j, a_k, b_w, b_i, b_j, b_k,
                scalar, output ready);
endinterface

[hw/rtl/qau_rsp_if.sv]
// ----------------------------------------------------------------------------
// qau_rsp_if
// Response channel: result quaternion, magnitude and status.
// ----------------------------------------------------------------------------
interface qau_rsp_if import qau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] r_w;
  logic signed [DATA_W-1:0] r_i;
  logic signed [DATA_W-1:0] r_j;
  logic signed [DATA_W-1:0] r_k;
  logic [NORM_W-1:0]        norm_value;
  logic [1:0]               status;

  modport source (output valid, r_w, r_i, r_j, r_k, norm_value, status, input ready);
  modport sink (input valid, r_w, r_i, r_j, r_k, norm_value, status, output ready);
endinterface

[hw/rtl/qau_front.sv]
// ----------------------------------------------------------------------------
// qau_front
// Four-stage front end: input register, products, sums, saturation.
// Produces add/sub/product/scale results and the sum of squares of A.
// ----------------------------------------------------------------------------
module qau_front import qau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  req_t             in_data,
  output logic             out_valid,
  output mid_t             out_mid,
  output logic [RAD_W-1:0] out_rad
);

  // sign of term t in component r of A*B; term t pairs a[t] with b[r^t]
  localparam logic [15:0] HAM_NEG = 16'h428E;
  localparam logic signed [SAT_W-1:0] HALF67 = SAT_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_W - 1);

  logic [3:0] v;

  req_t p1;

  logic [2:0]               op2;
  word_t [3:0]              a2;
  word_t                    s2;
  logic signed [63:0]       hp2 [4][4];
  logic signed [63:0]       sp2 [4];
  logic [63:0]              qp2 [4];
  logic signed [DATA_W:0]   as2 [4];

  logic [2:0]               op3;
  word_t [3:0]              a3;
  word_t                    s3;
  logic signed [SAT_W-1:0]  hs3 [4];
  logic signed [63:0]       ss3 [4];
  logic signed [DATA_W:0]   as3 [4];
  logic [RAD_W:0]           sq3;

  logic signed [SAT_W-1:0]  hsum [4];
  logic signed [SAT_W-1:0]  val [4];
  word_t [3:0]              rf;
  logic                     f;

  mid_t                     m4;
  logic [RAD_W-1:0]         rad4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2 <= p1.op;
      a2  <= p1.a;
      s2  <= p1.s;
      for (int r = 0; r < 4; r++) begin
        for (int t = 0; t < 4; t++) begin
          hp2[r][t] <= $signed(p1.a[t]) * $signed(p1.b[r ^ t]);
        end
      end
      for (int n = 0; n < 4; n++) begin
        sp2[n] <= $signed(p1.a[n]) * $signed(p1.s);
        qp2[n] <= $signed(p1.a[n]) * $signed(p1.a[n]);
        if (p1.op == OP_SUB) begin
          as2[n] <= $signed({p1.a[n][DATA_W-1], p1.a[n]})
                  - $signed({p1.b[n][DATA_W-1], p1.b[n]});
        end else begin
          as2[n] <= $signed({p1.a[n][DATA_W-1], p1.a[n]})
                  + $signed({p1.b[n][DATA_W-1], p1.b[n]});
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      hsum[r] = HALF67;
      for (int t = 0; t < 4; t++) begin
        if (HAM_NEG[r*4+t]) begin
          hsum[r] = hsum[r] - SAT_W'(hp2[r][t]);
        end else begin
          hsum[r] = hsum[r] + SAT_W'(hp2[r][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3 <= op2;
      a3  <= a2;
      s3  <= s2;
      for (int n = 0; n < 4; n++) begin
        hs3[n] <= hsum[n];
        ss3[n] <= sp2[n] + HALF64;
        as3[n] <= as2[n];
      end
      sq3 <= (RAD_W+1)'(qp2[0]) + (RAD_W+1)'(qp2[1])
           + (RAD_W+1)'(qp2[2]) + (RAD_W+1)'(qp2[3]);
    end
  end

  always_comb begin
    f = 1'b0;
    for (int n = 0; n < 4; n++) begin
      case (op3) inside
        OP_ADD, OP_SUB: val[n] = SAT_W'(as3[n]);
        OP_HAM:         val[n] = hs3[n] >>> FRAC_W;
        OP_SCALE:       val[n] = SAT_W'(ss3[n] >>> FRAC_W);
        default:        val[n] = '0;
      endcase
      rf[n] = sat_val(val[n]);
      f     = f | sat_ovf(val[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4.op    <= op3;
      m4.a     <= a3;
      m4.s     <= s3;
      m4.rf    <= rf;
      m4.f     <= f;
      m4.carry <= sq3[RAD_W];
      rad4     <= sq3[RAD_W-1:0];
    end
  end

  assign out_valid = v[3];
  assign out_mid   = m4;
  assign out_rad   = rad4;

endmodule

[hw/rtl/qau_sqrt.sv]
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives the floor root and the remainder; a side word rides along.
// ----------------------------------------------------------------------------
module qau_sqrt import qau_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [ROOT_W+1:0] rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld    [1:STEPS];
  logic [RAD_W-1:0]  rad_r  [1:STEPS];
  logic [ROOT_W-1:0] root_r [1:STEPS];
  logic [REM_W-1:0]  rem_r  [1:STEPS];
  logic [SIDE_W-1:0] side_r [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic              sv;
    logic [RAD_W-1:0]  srad;
    logic [ROOT_W-1:0] sroot;
    logic [REM_W-1:0]  srem;
    logic [SIDE_W-1:0] sside;
    logic [REM_W+1:0]  sh;
    logic [REM_W+2:0]  df;
    logic              ge;

    if (j == 0) begin : g_first
      assign sv    = in_valid;
      assign srad  = rad;
      assign sroot = '0;
      assign srem  = '0;
      assign sside = in_side;
    end else begin : g_next
      assign sv    = vld[j];
      assign srad  = rad_r[j];
      assign sroot = root_r[j];
      assign srem  = rem_r[j];
      assign sside = side_r[j];
    end

    assign sh = {srem, srad[RAD_W-1-2*j -: 2]};
    assign df = {1'b0, sh} - {3'b000, sroot, 2'b01};
    assign ge = ~df[REM_W+2];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[j+1]  <= srad;
        root_r[j+1] <= {sroot[ROOT_W-2:0], ge};
        rem_r[j+1]  <= ge ? df[REM_W-1:0] : sh[REM_W-1:0];
        side_r[j+1] <= sside;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = root_r[STEPS];
  assign rem       = rem_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

[hw/rtl/qau_div.sv]
// ----------------------------------------------------------------------------
// qau_div
// Four-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. Flags a lane whose quotient would not fit the data width.
// ----------------------------------------------------------------------------
module qau_div import qau_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [3:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [3:0][DATA_W-1:0] quot,
  output logic [3:0]             ovf,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int STEPS = DATA_W;

  logic                   vld    [1:STEPS];
  logic [3:0][DEN_W-1:0]  rem_r  [1:STEPS];
  logic [3:0][DATA_W-1:0] low_r  [1:STEPS];
  logic [3:0][DATA_W-1:0] quo_r  [1:STEPS];
  logic [3:0]             ovf_r  [1:STEPS];
  logic [DEN_W-1:0]       den_r  [1:STEPS];
  logic [SIDE_W-1:0]      side_r [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic                   sv;
    logic [3:0][DEN_W-1:0]  srem;
    logic [3:0][DATA_W-1:0] slow;
    logic [3:0][DATA_W-1:0] squo;
    logic [3:0]             sovf;
    logic [DEN_W-1:0]       sden;
    logic [SIDE_W-1:0]      sside;
    logic [3:0][DEN_W+1:0]  sh;
    logic [3:0][DEN_W+1:0]  df;
    logic [3:0][DEN_W-1:0]  nrem;
    logic [3:0][DATA_W-1:0] nquo;

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          srem[l] = DEN_W'(num[l][NUM_W-1:DATA_W]);
          slow[l] = num[l][DATA_W-1:0];
          sovf[l] = DEN_W'(num[l][NUM_W-1:DATA_W]) >= den;
        end
      end
      assign squo  = '0;
      assign sv    = in_valid;
      assign sden  = den;
      assign sside = in_side;
    end else begin : g_next
      assign srem  = rem_r[j];
      assign slow  = low_r[j];
      assign squo  = quo_r[j];
      assign sovf  = ovf_r[j];
      assign sv    = vld[j];
      assign sden  = den_r[j];
      assign sside = side_r[j];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        sh[l] = {1'b0, srem[l], slow[l][DATA_W-1-j]};
        df[l] = sh[l] - {2'b00, sden};
        if (!df[l][DEN_W+1]) begin
          nrem[l] = df[l][DEN_W-1:0];
        end else begin
          nrem[l] = sh[l][DEN_W-1:0];
        end
        nquo[l] = {squo[l][DATA_W-2:0], ~df[l][DEN_W+1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1]  <= nrem;
        low_r[j+1]  <= slow;
        quo_r[j+1]  <= nquo;
        ovf_r[j+1]  <= sovf;
        den_r[j+1]  <= sden;
        side_r[j+1] <= sside;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign quot      = quo_r[STEPS];
  assign ovf       = ovf_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

[hw/rtl/quaternion_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Quaternion ALU on signed Q16.16: add, sub, Hamilton product, scale,
// divide by scalar, normalize and magnitude, with saturation status.
//
// Channels: req (sink) carries one operation per beat; rsp (source) returns
// exactly one result beat per request beat, in order. Both use valid/ready.
// Throughput: one beat per cycle while the output queue has room. The path
// is a 4-stage front end (multipliers and adders), 32 square-root stages,
// two stages that round the root, pick the divisor and build the
// dividends, 32 divider stages, then a two-entry output queue.
// Every op travels the whole path, so latency is the same for all ops.
// Reset clears all valid bits and empties the output queue; no state is
// kept between beats. When rsp stalls, the output queue absorbs one more
// result; once it is full, req.ready drops and the pipeline holds in place.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
  input logic     clk,
  input logic     rst,
  qau_req_if.sink   req,
  qau_rsp_if.source rsp
);

  localparam int MID_W  = $bits(mid_t);
  localparam int TAIL_W = $bits(tail_t);
  localparam logic signed [SAT_W-1:0] BIG = SAT_W'(1) <<< (DATA_W + 1);

  logic adv;

  req_t             rq;
  logic             fv;
  mid_t             fm;
  logic [RAD_W-1:0] frad;

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [ROOT_W+1:0] sq_rem;
  logic [MID_W-1:0]  sq_side;
  mid_t              sq_mid;

  logic             vr;
  logic [DEN_W-1:0] m_r;
  mid_t             mid_r;

  word_t [3:0]           abs_a;
  word_t                 abs_s;
  logic [DEN_W-1:0]      den;
  logic [3:0][NUM_W-1:0] num;
  tail_t                 tl;

  logic                  vp;
  logic [3:0][NUM_W-1:0] num_p;
  logic [DEN_W-1:0]      den_p;
  tail_t                 tail_p;

  logic                   vd;
  logic [3:0][DATA_W-1:0] quot;
  logic [3:0]             dovf;
  logic [TAIL_W-1:0]      dside;
  tail_t                  td;

  logic signed [DATA_W+1:0] qv [4];
  logic signed [SAT_W-1:0]  dval [4];
  word_t [3:0]              dq;
  logic                     fdiv;
  rsp_t                     fin;

  rsp_t       fifo_mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign adv       = (cnt != 2'd2);
  assign req.ready = adv;

  assign rq.op   = req.req_type;
  assign rq.a[0] = req.a_w;
  assign rq.a[1] = req.a_i;
  assign rq.a[2] = req.a_j;
  assign rq.a[3] = req.a_k;
  assign rq.b[0] = req.b_w;
  assign rq.b[1] = req.b_i;
  assign rq.b[2] = req.b_j;
  assign rq.b[3] = req.b_k;
  assign rq.s    = req.scalar;

  qau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req.valid),
    .in_data   (rq),
    .out_valid (fv),
    .out_mid   (fm),
    .out_rad   (frad)
  );

  qau_sqrt #(.SIDE_W(MID_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fv),
    .rad       (frad),
    .in_side   (fm),
    .out_valid (sq_v),
    .root      (sq_root),
    .rem       (sq_rem),
    .out_side  (sq_side)
  );

  assign sq_mid = mid_t'(sq_side);

  // round the root to nearest; a wrapped sum of squares pins it at 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r <= sq_mid;
      if (sq_mid.carry) begin
        m_r <= {1'b1, {ROOT_W{1'b0}}};
      end else begin
        m_r <= {1'b0, sq_root} + DEN_W'(sq_rem > {2'b00, sq_root});
      end
    end
  end

  always_comb begin
    abs_s = mid_r.s[DATA_W-1] ? (~mid_r.s + 1'b1) : mid_r.s;
    if (mid_r.op == OP_DIV) begin
      den = {1'b0, abs_s};
    end else begin
      den = m_r;
    end
    for (int n = 0; n < 4; n++) begin
      abs_a[n]  = mid_r.a[n][DATA_W-1] ? (~mid_r.a[n] + 1'b1) : mid_r.a[n];
      num[n]    = {abs_a[n], {FRAC_W{1'b0}}} + NUM_W'(den >> 1);
      tl.neg[n] = mid_r.a[n][DATA_W-1] ^ ((mid_r.op == OP_DIV) & mid_r.s[DATA_W-1]);
    end
    tl.op   = mid_r.op;
    tl.rf   = mid_r.rf;
    tl.f    = mid_r.f;
    tl.divz = (den == '0);
    tl.fmag = (m_r > NORM_MAX);
    tl.nv   = tl.fmag ? NORM_MAX[NORM_W-1:0] : m_r[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_p  <= num;
      den_p  <= den;
      tail_p <= tl;
    end
  end

  qau_div #(.SIDE_W(TAIL_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vp),
    .num       (num_p),
    .den       (den_p),
    .in_side   (tail_p),
    .out_valid (vd),
    .quot      (quot),
    .ovf       (dovf),
    .out_side  (dside)
  );

  assign td = tail_t'(dside);

  always_comb begin
    fdiv = 1'b0;
    for (int n = 0; n < 4; n++) begin
      qv[n] = $signed({2'b00, quot[n]});
      if (dovf[n]) begin
        dval[n] = td.neg[n] ? -BIG : BIG;
      end else if (td.neg[n]) begin
        dval[n] = SAT_W'(-qv[n]);
      end else begin
        dval[n] = SAT_W'(qv[n]);
      end
      dq[n] = sat_val(dval[n]);
      fdiv  = fdiv | sat_ovf(dval[n]);
    end
    fin = '0;
    case (td.op) inside
      OP_ADD, OP_SUB, OP_HAM, OP_SCALE: begin
        fin.r      = td.rf;
        fin.status = td.f ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (td.divz) begin
          fin.status = ST_DIVZ;
        end else begin
          fin.r      = dq;
          fin.status = fdiv ? ST_SAT : ST_OK;
        end
      end
      OP_NORM: begin
        if (td.divz) begin
          fin.status = ST_DIVZ;
        end else begin
          fin.r      = dq;
          fin.nv     = td.nv;
          fin.status = (fdiv | td.fmag) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        fin.nv     = td.nv;
        fin.status = td.fmag ? ST_SAT : ST_OK;
      end
      default: fin = '0;
    endcase
  end

  // two-entry output queue
  assign push = adv & vd;
  assign pop  = rsp.valid & rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wp] <= fin;
    end
  end

  assign rsp.valid      = (cnt != 2'd0);
  assign rsp.r_w        = fifo_mem[rp].r[0];
  assign rsp.r_i        = fifo_mem[rp].r[1];
  assign rsp.r_j        = fifo_mem[rp].r[2];
  assign rsp.r_k        = fifo_mem[rp].r[3];
  assign rsp.norm_value = fifo_mem[rp].nv;
  assign rsp.status     = fifo_mem[rp].status;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_DIVZ |->
      rsp.r_w == 0 && rsp.r_i == 0 && rsp.r_j == 0 && rsp.r_k == 0 &&
      rsp.norm_value == 0)
    else $error("divide-by-zero beat carries nonzero data");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(vd))
    else $error("response appeared without a divider output");

endmodule

[test/qau_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qau_result_checker
// Watches the request and response channels of the quaternion unit, computes
// the expected result of every accepted request beat and compares each
// response beat against the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module qau_result_checker import qau_pkg::*; (
  input  logic clk,
  input  logic rst,
  qau_req_if   req,
  qau_rsp_if   rsp,
  output int   outstanding,
  output int   errors
);

  typedef logic signed [127:0] wide_t;

  rsp_t results_due[$];

  function automatic word_t clamp_word(input wide_t v, inout logic clipped);
    if (v > 128'sh7fff_ffff) begin
      clipped = 1'b1;
      return MAX_WORD;
    end
    if (v < -128'sh8000_0000) begin
      clipped = 1'b1;
      return MIN_WORD;
    end
    return v[DATA_W-1:0];
  endfunction

  // nearest, ties away from zero
  function automatic wide_t div_nearest(input wide_t num, input wide_t den);
    wide_t n, d, q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + d / 2) / d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic wide_t quat_length(input wide_t a [4]);
    wide_t sum, root;
    sum = 0;
    foreach (a[n]) sum += a[n] * a[n];
    if (sum >= (128'sd1 <<< 64)) return 128'sd1 <<< 32;
    root = 0;
    for (int b = 32; b >= 0; b--) begin
      if (((root | (128'sd1 <<< b)) * (root | (128'sd1 <<< b))) <= sum)
        root |= (128'sd1 <<< b);
    end
    if (sum - root * root > root) root += 1;
    return root;
  endfunction

  function automatic rsp_t quat_alu(input logic [2:0] op, input wide_t a [4],
                                    input wide_t b [4], input wide_t s);
    rsp_t  o;
    logic  clipped;
    logic  divz;
    wide_t acc [4];
    wide_t len;
    clipped = 1'b0;
    divz    = 1'b0;
    o       = '0;
    case (op)
      OP_ADD: for (int n = 0; n < 4; n++) o.r[n] = clamp_word(a[n] + b[n], clipped);
      OP_SUB: for (int n = 0; n < 4; n++) o.r[n] = clamp_word(a[n] - b[n], clipped);
      OP_HAM: begin
        acc[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        acc[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        acc[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
        acc[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
        for (int n = 0; n < 4; n++)
          o.r[n] = clamp_word((acc[n] + (128'sd1 <<< (FRAC_W-1))) >>> FRAC_W, clipped);
      end
      OP_SCALE: for (int n = 0; n < 4; n++)
        o.r[n] = clamp_word((a[n] * s + (128'sd1 <<< (FRAC_W-1))) >>> FRAC_W, clipped);
      OP_DIV: begin
        if (s == 0) divz = 1'b1;
        else for (int n = 0; n < 4; n++)
          o.r[n] = clamp_word(div_nearest(a[n] <<< FRAC_W, s), clipped);
      end
      OP_NORM, OP_MAG: begin
        len = quat_length(a);
        if (len > 128'sh7fff_ffff) begin
          o.nv    = '1;
          clipped = 1'b1;
        end else begin
          o.nv = len[NORM_W-1:0];
        end
        if (op == OP_NORM) begin
          if (len == 0) begin
            divz = 1'b1;
            o.nv = '0;
          end else for (int n = 0; n < 4; n++)
            o.r[n] = clamp_word(div_nearest(a[n] <<< FRAC_W, len), clipped);
        end
      end
      default: ;
    endcase
    o.status = divz ? ST_DIVZ : (clipped ? ST_SAT : ST_OK);
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  wide_t qa [4];
  wide_t qb [4];
  rsp_t  want;

  always @(posedge clk) begin
    if (rst) begin
      results_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        qa[0] = req.a_w; qa[1] = req.a_i; qa[2] = req.a_j; qa[3] = req.a_k;
        qb[0] = req.b_w; qb[1] = req.b_i; qb[2] = req.b_j; qb[3] = req.b_k;
        results_due.push_back(quat_alu(req.req_type, qa, qb, wide_t'(req.scalar)));
      end
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t mismatch: unexpected result beat, expected none actual %h %h %h %h",
                   $time, rsp.r_w, rsp.r_i, rsp.r_j, rsp.r_k);
        end else begin
          want = results_due.pop_front();
          compare_field("r_w", want.r[0], rsp.r_w);
          compare_field("r_i", want.r[1], rsp.r_i);
          compare_field("r_j", want.r[2], rsp.r_j);
          compare_field("r_k", want.r[3], rsp.r_k);
          compare_field("norm_value", 32'(want.nv), 32'(rsp.norm_value));
          compare_field("status", 32'(want.status), 32'(rsp.status));
        end
      end
    end
    outstanding = results_due.size();
  end

  initial begin
    errors      = 0;
    outstanding = 0;
  end

endmodule

[test/quaternion_arithmetic_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Drives directed corner beats and then random operations into the
// quaternion unit with random gaps and response stalls, including one long
// stall that backs up the pipeline; a checker compares every result.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;
  import qau_pkg::*;

  localparam int RANDOM_BEATS = 800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam word_t ONE       = 32'h0001_0000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk;
  logic rst;
  int   cycles;
  int   outstanding;
  int   errors;
  logic stim_done;

  qau_req_if req ();
  qau_rsp_if rsp ();

  quaternion_arithmetic_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  qau_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: return MAX_WORD;
          1: return MIN_WORD;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
      4: return word_t'($urandom_range(0, 32'h0000_0400)) - 32'h0000_0200;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] op, input word_t a [4], input word_t b [4],
                           input word_t s);
    logic took;
    req.valid    <= 1'b1;
    req.req_type <= op;
    req.a_w <= a[0]; req.a_i <= a[1]; req.a_j <= a[2]; req.a_k <= a[3];
    req.b_w <= b[0]; req.b_i <= b[1]; req.b_j <= b[2]; req.b_k <= b[3];
    req.scalar   <= s;
    forever begin
      @(negedge clk);
      took = req.ready;
      @(posedge clk);
      if (took) break;
    end
  endtask

  task automatic send_uniform(input logic [2:0] op, input word_t av, input word_t bv,
                              input word_t s);
    word_t a [4];
    word_t b [4];
    foreach (a[n]) begin
      a[n] = av;
      b[n] = bv;
    end
    send_beat(op, a, b, s);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response stalls, with one long hold-off partway through
  initial begin
    int n;
    logic long_done;
    long_done = 1'b0;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!long_done && cycles > 1500) begin
        long_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      n = gap_len();
      if (cycles > 5000 && cycles < 6500) n = 0;
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    logic [2:0] op;
    word_t qa [4];
    word_t qb [4];
    word_t sc;
    cycles    = 0;
    stim_done = 1'b0;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.req_type = OP_ADD;
    req.a_w = '0; req.a_i = '0; req.a_j = '0; req.a_k = '0;
    req.b_w = '0; req.b_i = '0; req.b_j = '0; req.b_k = '0;
    req.scalar = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_uniform(OP_ADD,   MAX_WORD, MAX_WORD, '0);
    send_uniform(OP_ADD,   ONE, -ONE, '0);
    send_uniform(OP_SUB,   MIN_WORD, MAX_WORD, '0);
    send_uniform(OP_SUB,   MAX_WORD, MIN_WORD, '0);
    send_uniform(OP_HAM,   ONE, ONE, '0);
    send_uniform(OP_HAM,   MIN_WORD, MIN_WORD, '0);
    send_uniform(OP_HAM,   MAX_WORD, MIN_WORD, '0);
    send_uniform(OP_SCALE, ONE, '0, ONE);
    send_uniform(OP_SCALE, MIN_WORD, '0, MIN_WORD);
    send_uniform(OP_SCALE, MAX_WORD, '0, -ONE);
    send_uniform(OP_DIV,   ONE, '0, '0);
    send_uniform(OP_DIV,   MAX_WORD, '0, 32'h1);
    send_uniform(OP_DIV,   MIN_WORD, '0, -ONE);
    send_uniform(OP_DIV,   32'h0003_0000, '0, 32'h0002_0000);
    send_uniform(OP_NORM,  '0, '0, '0);
    send_uniform(OP_NORM,  ONE, '0, '0);
    send_uniform(OP_NORM,  MIN_WORD, '0, '0);
    send_uniform(OP_NORM,  32'h1, '0, '0);
    send_uniform(OP_MAG,   MAX_WORD, '0, '0);
    send_uniform(OP_MAG,   MIN_WORD, '0, '0);
    send_uniform(OP_MAG,   '0, '0, '0);
    send_uniform(OP_UNUSED, MAX_WORD, MIN_WORD, ONE);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      idle_cycles(gap_len());
      op = 3'($urandom_range(0, 7));
      foreach (qa[n]) begin
        qa[n] = pick_word();
        qb[n] = pick_word();
      end
      sc = ($urandom_range(0, 19) == 0) ? '0 : pick_word();
      if (op == OP_NORM && $urandom_range(0, 19) == 0) foreach (qa[n]) qa[n] = '0;
      send_beat(op, qa, qb, sc);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;

    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
